FILE: hdl/toeq_pkg.sv
// Shared types and constants for the timestamp-ordered event queue.
package toeq_pkg;

    // Queue capacity and derived widths
    localparam int QUEUE_DEPTH = 64;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int TIME_W      = 31;
    localparam int PROC_W      = 8;
    localparam int TRANS_W     = 3;
    localparam int COUNT_OUT_W = 7;

    // Stream word widths (packed fields, padded to whole bytes)
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 88;

    // Operation codes carried in the input tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // One stored event
    typedef struct packed {
        logic [TIME_W-1:0]  time_stamp;
        logic [PROC_W-1:0]  proc_id;
        logic [TRANS_W-1:0] trans;
    } t_event;

    // Command broadcast to every cell
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_event ev;
    } t_cmd;

    // What a cell shows its neighbors and the top level
    typedef struct packed {
        logic              occ;
        logic              keep;
        t_event            ev;
        logic              nxt_occ;
        logic [TIME_W-1:0] nxt_time;
    } t_link;

endpackage

FILE: hdl/timestamp_ordered_event_queue.sv
// Top level of the timestamp-ordered event queue: cell chain and result register.
//
// Usage:
//   Input words arrive on the s-side stream. tuser selects the operation
//   (0 inserts the event in tdata, 1 pops the earliest event). Every accepted
//   word yields exactly one result word on the m-side stream.
//   Events are kept in a row of QUEUE_DEPTH cells in ascending timestamp
//   order; an insert lands after all stored events with an equal or smaller
//   timestamp, so equal timestamps leave in arrival order. Each cell compares
//   its own timestamp with the new one in the same cycle and shifts toward
//   its neighbor, so one word is taken per cycle while the receiver takes results.
//   The result word is registered and valid in the cycle after its input is accepted.
//   Throughput: one word per cycle while the receiver takes results; the
//   single result register is refilled in the same cycle it is drained.
//   An insert into a full queue is dropped and reported with overflow set.
//   Reset (synchronous, active low) empties the queue at once and drops any
//   pending result word; no clearing pass is needed.
//   When the receiver stalls, the pending result holds and s_tready drops
//   until it is taken.
module timestamp_ordered_event_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: event_time[30:0], process_id[38:31], transition_kind[41:39], zero pad
    input  logic [toeq_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: mode[0]
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: popped_time[30:0], popped_process[38:31], popped_transition[41:39],
    //        head_valid[42], head_time[73:43], queue_count[80:74], overflow[81], zero pad
    output logic [toeq_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: pop_valid[0]
    output logic                               o_m_tuser
);
    import toeq_pkg::*;

    localparam int PAD_W = OUT_DATA_W - (2 * TIME_W + PROC_W + TRANS_W + COUNT_OUT_W + 2);

    t_link             w_link [QUEUE_DEPTH];
    t_link             w_head_prev;
    t_link             w_tail_next;
    t_cmd              w_cmd;
    t_event            w_in_ev;
    logic              w_accept;
    logic              w_full;
    logic              w_is_pop;
    logic              w_is_ins;
    logic              w_do_pop;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              r_pop_valid;
    t_event            r_popped;
    logic              r_head_valid;
    logic [TIME_W-1:0] r_head_time;
    logic [COUNT_OUT_W-1:0] r_count_out;
    logic              r_overflow;

    // Accept while the result register is empty or being drained
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_in_ev.time_stamp = i_s_tdata[TIME_W-1:0];
    assign w_in_ev.proc_id    = i_s_tdata[TIME_W+PROC_W-1:TIME_W];
    assign w_in_ev.trans      = i_s_tdata[TIME_W+PROC_W+TRANS_W-1:TIME_W+PROC_W];

    assign w_full   = w_link[QUEUE_DEPTH-1].occ;
    assign w_is_pop = (i_s_tuser == MODE_POP);
    assign w_is_ins = (i_s_tuser == MODE_INSERT);
    assign w_do_pop = w_accept && w_is_pop && w_link[0].occ;

    assign w_cmd.insert = w_accept && w_is_ins && !w_full;
    assign w_cmd.pop    = w_do_pop;
    assign w_cmd.ev     = w_in_ev;

    // Boundary links: ahead of the first cell a kept, occupied slot; past the last, empty
    always_comb begin
        w_head_prev          = '0;
        w_head_prev.occ      = 1'b1;
        w_head_prev.keep     = 1'b1;
        w_tail_next          = '0;
    end

    // Row of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0 && g == QUEUE_DEPTH - 1) begin : g_only
            toeq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (w_cmd),
                .i_prev (w_head_prev),
                .i_next (w_tail_next),
                .o_link (w_link[g])
            );
        end else if (g == 0) begin : g_first
            toeq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (w_cmd),
                .i_prev (w_head_prev),
                .i_next (w_link[g+1]),
                .o_link (w_link[g])
            );
        end else if (g == QUEUE_DEPTH - 1) begin : g_last
            toeq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (w_cmd),
                .i_prev (w_link[g-1]),
                .i_next (w_tail_next),
                .o_link (w_link[g])
            );
        end else begin : g_mid
            toeq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (w_cmd),
                .i_prev (w_link[g-1]),
                .i_next (w_link[g+1]),
                .o_link (w_link[g])
            );
        end
    end

    // Advance the event count
    always_comb begin
        n_count = r_count;
        if (w_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Count and result-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_valid  <= w_do_pop;
            r_popped     <= w_do_pop ? w_link[0].ev : '0;
            r_head_valid <= w_link[0].nxt_occ;
            r_head_time  <= w_link[0].nxt_occ ? w_link[0].nxt_time : '0;
            r_count_out  <= COUNT_OUT_W'(n_count);
            r_overflow   <= w_is_ins && w_full;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_pop_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_overflow, r_count_out, r_head_time, r_head_valid,
                         r_popped.trans, r_popped.proc_id, r_popped.time_stamp};

endmodule

FILE: hdl/toeq_cell.sv
// One slot of the sorted shift-register queue.
module toeq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  toeq_pkg::t_cmd  i_cmd,
    input  toeq_pkg::t_link i_prev,
    input  toeq_pkg::t_link i_next,
    output toeq_pkg::t_link o_link
);
    import toeq_pkg::*;

    logic   r_occ;
    t_event r_ev;
    logic   n_occ;
    t_event n_ev;
    logic   w_keep;

    // Stay in place on insert when occupied and not later than the new event
    assign w_keep = r_occ && (r_ev.time_stamp <= i_cmd.ev.time_stamp);

    // Pick next slot content: hold, take new event, shift up, or shift down
    always_comb begin
        n_occ = r_occ;
        n_ev  = r_ev;
        if (i_cmd.insert) begin
            n_occ = r_occ | i_prev.occ;
            if (w_keep) begin
                n_ev = r_ev;
            end else if (i_prev.keep) begin
                n_ev = i_cmd.ev;
            end else begin
                n_ev = i_prev.ev;
            end
        end else if (i_cmd.pop) begin
            n_occ = i_next.occ;
            n_ev  = i_next.ev;
        end
    end

    // Occupied flag is control state; event payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= n_ev;
    end

    assign o_link.occ      = r_occ;
    assign o_link.keep     = w_keep;
    assign o_link.ev       = r_ev;
    assign o_link.nxt_occ  = n_occ;
    assign o_link.nxt_time = n_ev.time_stamp;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the timestamp-ordered event queue stream block.
module testbench;
    import toeq_pkg::*;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_PRINTS  = 40;

    // Command and result as seen on the two streams
    typedef struct packed {
        logic   mode;
        t_event ev;
    } t_queue_cmd;

    typedef struct packed {
        logic                   pop_valid;
        t_event                 popped;
        logic                   head_valid;
        logic [TIME_W-1:0]      head_time;
        logic [COUNT_OUT_W-1:0] count;
        logic                   overflow;
    } t_queue_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  i_s_tuser  = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tuser;

    // Predictor state and scoreboard
    t_event        event_list[$];
    t_queue_result expected_results[$];
    t_queue_cmd    pending_cmds[$];

    int  words_issued   = 0;
    int  words_accepted = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  send_gap       = 0;
    int  recv_wait      = 0;
    int  hold_left      = 0;
    int  hold_ticket    = 0;
    int  hold_seen      = 0;
    bit  send_idle_on   = 1'b0;
    bit  recv_idle_on   = 1'b0;
    logic in_word_taken  = 1'b0;
    logic out_word_taken = 1'b0;

    timestamp_ordered_event_queue uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Log one mismatch and count it
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
        end
    endtask

    // Apply one command to the sorted event list and build the result word
    function automatic t_queue_result predict_queue_step(input t_queue_cmd cmd);
        t_queue_result res;
        int            pos;
        res = '0;
        if (cmd.mode == MODE_INSERT) begin
            if (event_list.size() >= QUEUE_DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                // land after every stored event with an equal or earlier time
                pos = 0;
                while (pos < event_list.size() &&
                       event_list[pos].time_stamp <= cmd.ev.time_stamp) begin
                    pos++;
                end
                event_list.insert(pos, cmd.ev);
            end
        end else if (event_list.size() > 0) begin
            res.pop_valid = 1'b1;
            res.popped    = event_list[0];
            event_list.delete(0);
        end
        if (event_list.size() > 0) begin
            res.head_valid = 1'b1;
            res.head_time  = event_list[0].time_stamp;
        end
        res.count = COUNT_OUT_W'(event_list.size());
        return res;
    endfunction

    // Compare one result word with the oldest expectation
    task automatic check_result_word();
        t_queue_result want;
        t_queue_result got;
        got.pop_valid         = o_m_tuser;
        got.popped.time_stamp = o_m_tdata[30:0];
        got.popped.proc_id    = o_m_tdata[38:31];
        got.popped.trans      = o_m_tdata[41:39];
        got.head_valid        = o_m_tdata[42];
        got.head_time         = o_m_tdata[73:43];
        got.count             = o_m_tdata[80:74];
        got.overflow          = o_m_tdata[81];
        if (expected_results.size() == 0) begin
            report_mismatch("result word with no expected result");
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.pop_valid !== want.pop_valid)
                report_mismatch($sformatf("pop_valid %b, want %b",
                                          got.pop_valid, want.pop_valid));
            if (got.popped.time_stamp !== want.popped.time_stamp)
                report_mismatch($sformatf("popped_time %0d, want %0d",
                                          got.popped.time_stamp, want.popped.time_stamp));
            if (got.popped.proc_id !== want.popped.proc_id)
                report_mismatch($sformatf("popped_process %0d, want %0d",
                                          got.popped.proc_id, want.popped.proc_id));
            if (got.popped.trans !== want.popped.trans)
                report_mismatch($sformatf("popped_transition %0d, want %0d",
                                          got.popped.trans, want.popped.trans));
            if (got.head_valid !== want.head_valid)
                report_mismatch($sformatf("head_valid %b, want %b",
                                          got.head_valid, want.head_valid));
            if (got.head_time !== want.head_time)
                report_mismatch($sformatf("head_time %0d, want %0d",
                                          got.head_time, want.head_time));
            if (got.count !== want.count)
                report_mismatch($sformatf("queue_count %0d, want %0d",
                                          got.count, want.count));
            if (got.overflow !== want.overflow)
                report_mismatch($sformatf("overflow %b, want %b",
                                          got.overflow, want.overflow));
        end
        results_seen++;
    endtask

    // Monitor: check result words, predict accepted input words
    always @(posedge i_clk) begin
        t_queue_cmd taken;
        if (!i_rst_n) begin
            in_word_taken  <= 1'b0;
            out_word_taken <= 1'b0;
        end else begin
            in_word_taken  <= i_s_tvalid && o_s_tready;
            out_word_taken <= o_m_tvalid && i_m_tready;
            if (o_m_tvalid && i_m_tready) begin
                check_result_word();
            end
            if (i_s_tvalid && o_s_tready) begin
                taken.mode          = i_s_tuser;
                taken.ev.time_stamp = i_s_tdata[30:0];
                taken.ev.proc_id    = i_s_tdata[38:31];
                taken.ev.trans      = i_s_tdata[41:39];
                expected_results.insert(expected_results.size(), predict_queue_step(taken));
                words_accepted++;
            end
        end
    end

    // Driver: present pending words, hold until taken, then wait a random gap when sender idling is on
    always @(negedge i_clk) begin
        t_queue_cmd next_cmd;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!i_s_tvalid || in_word_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                next_cmd = pending_cmds[0];
                pending_cmds.delete(0);
                i_s_tdata <= {{(IN_DATA_W - TIME_W - PROC_W - TRANS_W){1'b0}},
                              next_cmd.ev.trans, next_cmd.ev.proc_id,
                              next_cmd.ev.time_stamp};
                i_s_tuser  <= next_cmd.mode;
                i_s_tvalid <= 1'b1;
                send_gap = send_idle_on ? $urandom_range(0, 15) : 0;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per result word, plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_seen != hold_ticket) begin
                hold_seen = hold_ticket;
                hold_left = LONG_HOLD;
            end
            if (out_word_taken) begin
                recv_wait = recv_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when neither stream moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Queue one command for the driver
    task automatic queue_cmd(input logic mode, input t_event ev);
        t_queue_cmd cmd;
        cmd.mode = mode;
        cmd.ev   = ev;
        pending_cmds.insert(pending_cmds.size(), cmd);
        words_issued++;
    endtask

    // Draw an event; tie-heavy draws use a narrow time range
    function automatic t_event random_event(input bit tie_heavy);
        t_event ev;
        int     pick;
        pick = $urandom_range(0, 9);
        if (tie_heavy || pick < 2) begin
            ev.time_stamp = TIME_W'($urandom_range(0, 7));
        end else if (pick == 2) begin
            ev.time_stamp = {TIME_W{1'b1}};
        end else begin
            ev.time_stamp = TIME_W'($urandom);
        end
        ev.proc_id = PROC_W'($urandom_range(0, 255));
        ev.trans   = TRANS_W'($urandom_range(0, 7));
        return ev;
    endfunction

    // Random mix of inserts and pops
    task automatic queue_mixed(input int count, input int insert_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1, 100) <= insert_pct) begin
                queue_cmd(MODE_INSERT, random_event($urandom_range(0, 3) == 0));
            end else begin
                queue_cmd(MODE_POP, random_event(1'b0));
            end
        end
    endtask

    // Run of inserts past capacity, then a run of pops
    task automatic queue_fill_drain(input int inserts, input int pops, input bit tie_heavy);
        for (int n = 0; n < inserts; n++) begin
            queue_cmd(MODE_INSERT, random_event(tie_heavy));
        end
        for (int n = 0; n < pops; n++) begin
            queue_cmd(MODE_POP, random_event(1'b0));
        end
    endtask

    // Block until every queued word is taken and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_accepted != words_issued || expected_results.size() != 0);
    endtask

    // Stimulus sequence
    initial begin
        t_event ev;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pop, time extremes, equal times, front insert, full drain
        queue_cmd(MODE_POP, '{time_stamp: {TIME_W{1'b1}}, proc_id: 8'hFF, trans: 3'h7});
        queue_cmd(MODE_INSERT, '{time_stamp: {TIME_W{1'b1}}, proc_id: 8'hFF, trans: 3'h7});
        queue_cmd(MODE_INSERT, '{time_stamp: '0, proc_id: 8'h00, trans: 3'h0});
        queue_cmd(MODE_INSERT, '{time_stamp: 31'd5, proc_id: 8'h01, trans: 3'h1});
        queue_cmd(MODE_INSERT, '{time_stamp: 31'd5, proc_id: 8'h02, trans: 3'h2});
        queue_cmd(MODE_INSERT, '{time_stamp: 31'd5, proc_id: 8'h03, trans: 3'h3});
        queue_cmd(MODE_INSERT, '{time_stamp: {TIME_W{1'b1}}, proc_id: 8'h04, trans: 3'h4});
        queue_cmd(MODE_INSERT, '{time_stamp: 31'd3, proc_id: 8'h05, trans: 3'h5});
        queue_cmd(MODE_INSERT, '{time_stamp: '0, proc_id: 8'h06, trans: 3'h6});
        ev = '0;
        for (int n = 0; n < 9; n++) begin
            queue_cmd(MODE_POP, ev);
        end
        wait_drained();

        // Random mix with both sides idling, then full-rate sender
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        queue_mixed(300, 55);
        wait_drained();
        send_idle_on = 1'b0;
        queue_mixed(200, 60);
        wait_drained();

        // Hold off the receiver at the start of a fill past capacity; the sender stalls until it resumes
        recv_idle_on = 1'b0;
        hold_ticket++;
        queue_fill_drain(68, 70, 1'b1);
        wait_drained();

        // Insert-heavy then pop-heavy random traffic with idling on both sides
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        queue_mixed(300, 70);
        wait_drained();
        queue_mixed(300, 35);
        wait_drained();

        // Second fill and drain over the whole time range
        queue_fill_drain(66, 66, 1'b0);
        wait_drained();

        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
